// File: hw/rtl/pftr_pkg.sv
package pftr_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH      = 128;
    localparam int PANEL_HEIGHT     = 32;
    localparam int PAGE_COUNT       = 4;
    localparam int MAX_GLYPH_WIDTH  = 32;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int FRAME_BYTES      = PAGE_COUNT * PANEL_WIDTH;
    localparam int ADDR_W           = $clog2(FRAME_BYTES);

    // Request modes
    localparam logic [1:0] MODE_PLOT  = 2'd0;
    localparam logic [1:0] MODE_GLYPH = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FONT_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FONT_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_START_X     = 2'd2;
    localparam logic [1:0] CFG_START_Y     = 2'd3;

    localparam logic [5:0] FONT_WIDTH_RST  = 6'd8;
    localparam logic [5:0] FONT_HEIGHT_RST = 6'd16;

    // Byte constants
    localparam logic [7:0]  BYTE_MSB   = 8'h80;
    localparam logic [7:0]  BYTE_LSB   = 8'h01;
    localparam logic [7:0]  BYTE_ONES  = 8'hff;
    localparam logic [7:0]  BYTE_ZERO  = 8'h00;
    localparam logic [31:0] PLOT_BIT   = {BYTE_MSB, 24'h000000};

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic        draw_white;
        logic [31:0] row_bits;
        logic [4:0]  row_number;
        logic        string_start;
    } request_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       background_white;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } ram_ctl_t;

endpackage

// File: hw/rtl/pftr_frame_ram.sv
module pftr_frame_ram (
    input  logic               clk,
    input  pftr_pkg::ram_ctl_t ctl,
    output logic [7:0]         rd_data
);
    import pftr_pkg::*;

    logic [7:0] mem [FRAME_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.addr] <= ctl.wdata;
        end
        rd_data_reg <= mem[ctl.addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/page_framebuffer_text_renderer.sv
// Page-organized monochrome frame store with a bitmap-font text renderer.
// Request channel: a request is taken at a rising edge with start high and
// busy low. Modes: plot one pixel, draw one glyph row at the text cursor,
// read one frame byte, clear the frame to the background color.
// Result channel: done is high for exactly one cycle per request, with
// result valid in that cycle; the receiver cannot stall it.
// Config port: cfg_we / cfg_index / cfg_data write a register at once; the user
// writes only while the block is idle, which the block itself does not enforce.
// Sequencing: glyph rows shift row_bits out one bit per cycle while no
// pixel is plotted; each plotted column adds a read-modify-write step on
// the single-port frame RAM. A plot scans one pixel the same way; a read
// issues the address (ST_RD_ISSUE), then captures the byte (ST_RD_DATA).
// A clear, or a draw in the background color (which flips the background
// and refills the frame), adds one full RAM sweep over FRAME_BYTES (512)
// bytes, one byte per cycle; a flip also repeats the pixel's scan step.
// Reset: rst_n clears control state, then a clearing pass over all 512 bytes
// zeroes the frame RAM with busy high; config writes are still taken meanwhile.
module page_framebuffer_text_renderer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pftr_pkg::request_t request,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    output logic               done,
    output pftr_pkg::result_t  result
);
    import pftr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_NEWC,
        ST_SCAN,
        ST_RMW,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    state_t            state_reg;
    request_t          req_reg;
    logic [5:0]        font_width_reg;
    logic [5:0]        font_height_reg;
    logic [6:0]        start_x_reg;
    logic [4:0]        start_y_reg;
    logic              bg_reg;
    logic [7:0]        cursor_col_reg;
    logic [6:0]        cursor_row_reg;
    logic [8:0]        x_reg;
    logic [7:0]        y_reg;
    logic [31:0]       bits_reg;
    logic [5:0]        rem_reg;
    logic [ADDR_W-1:0] fill_reg;
    logic              pending_reg;
    logic              done_reg;
    logic [7:0]        frame_byte_reg;

    ram_ctl_t          ram_ctl;
    logic [7:0]        ram_rd_data;

    // Clamped glyph size
    logic [5:0]        glyph_w;
    logic [5:0]        glyph_h;

    // Current pixel
    logic              pix_in;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_mask;
    logic              plot_hit;
    logic              need_flip;

    // Read request
    logic              rd_in;
    logic [ADDR_W-1:0] rd_addr;

    // New-character cursor placement
    logic [7:0]        nc_x0;
    logic [7:0]        nc_y0;
    logic              nc_wrap_line;
    logic [7:0]        nc_x1;
    logic [7:0]        nc_y1;
    logic              nc_wrap_page;
    logic [7:0]        nc_x2;
    logic [7:0]        nc_y2;

    // Cursor advance after last glyph row
    logic [8:0]        col_adv;
    logic [7:0]        col_sat;
    logic              last_row;
    logic              row_past;

    always_comb
    begin
        if (font_width_reg == 6'd0)
            glyph_w = 6'd1;
        else if (font_width_reg > 6'(MAX_GLYPH_WIDTH))
            glyph_w = 6'(MAX_GLYPH_WIDTH);
        else
            glyph_w = font_width_reg;

        if (font_height_reg == 6'd0)
            glyph_h = 6'd1;
        else if (font_height_reg > 6'(MAX_GLYPH_HEIGHT))
            glyph_h = 6'(MAX_GLYPH_HEIGHT);
        else
            glyph_h = font_height_reg;
    end

    assign pix_in    = (x_reg < 9'(PANEL_WIDTH)) && (y_reg < 8'(PANEL_HEIGHT))
                       && ((y_reg >> 3) < 8'(PAGE_COUNT));
    assign pix_addr  = ADDR_W'(y_reg >> 3) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(x_reg);
    assign pix_mask  = BYTE_LSB << y_reg[2:0];
    assign plot_hit  = bits_reg[31] && pix_in;
    assign need_flip = (req_reg.draw_white == bg_reg);

    assign rd_in   = (9'(req_reg.pixel_x) < 9'(PANEL_WIDTH))
                     && ((req_reg.pixel_y >> 3) < 8'(PAGE_COUNT));
    assign rd_addr = ADDR_W'(req_reg.pixel_y >> 3) * ADDR_W'(PANEL_WIDTH)
                     + ADDR_W'(req_reg.pixel_x);

    // Wrap to next text line, then back to start if the page is full
    always_comb
    begin
        nc_x0 = req_reg.string_start ? 8'(start_x_reg) : cursor_col_reg;
        nc_y0 = req_reg.string_start ? 8'(start_y_reg) : 8'(cursor_row_reg);
        nc_wrap_line = (9'(nc_x0) + 9'(glyph_w)) > 9'(PANEL_WIDTH);
        nc_x1 = nc_wrap_line ? 8'(start_x_reg) : nc_x0;
        nc_y1 = nc_wrap_line ? nc_y0 + 8'(glyph_h) : nc_y0;
        nc_wrap_page = (9'(nc_y1) + 9'(glyph_h)) > 9'(PANEL_HEIGHT);
        nc_x2 = nc_wrap_page ? 8'(start_x_reg) : nc_x1;
        nc_y2 = nc_wrap_page ? 8'(start_y_reg) : nc_y1;
    end

    assign col_adv  = 9'(cursor_col_reg) + 9'(glyph_w);
    assign col_sat  = (col_adv > 9'(BYTE_ONES)) ? BYTE_ONES : col_adv[7:0];
    assign last_row = (6'(req_reg.row_number) == glyph_h - 6'd1);
    assign row_past = (6'(request.row_number) >= glyph_h);

    // Frame RAM port: fill sweep, byte read, or pixel read-modify-write
    always_comb
    begin
        ram_ctl.we = (state_reg == ST_FILL) || (state_reg == ST_RMW);
        if (state_reg == ST_FILL)
            ram_ctl.addr = fill_reg;
        else if (state_reg == ST_RD_ISSUE)
            ram_ctl.addr = rd_addr;
        else
            ram_ctl.addr = pix_addr;
        if (state_reg == ST_FILL)
            ram_ctl.wdata = bg_reg ? BYTE_ONES : BYTE_ZERO;
        else if (req_reg.draw_white)
            ram_ctl.wdata = ram_rd_data | pix_mask;
        else
            ram_ctl.wdata = ram_rd_data & ~pix_mask;
    end

    pftr_frame_ram u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_FILL;
            req_reg         <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            bits_reg        <= '0;
            rem_reg         <= '0;
            fill_reg        <= '0;
            pending_reg     <= 1'b0;
            bg_reg          <= 1'b0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            font_width_reg  <= FONT_WIDTH_RST;
            font_height_reg <= FONT_HEIGHT_RST;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            done_reg        <= 1'b0;
            frame_byte_reg  <= BYTE_ZERO;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FONT_WIDTH:  font_width_reg  <= cfg_data[5:0];
                    CFG_FONT_HEIGHT: font_height_reg <= cfg_data[5:0];
                    CFG_START_X:     start_x_reg     <= cfg_data;
                    CFG_START_Y:     start_y_reg     <= cfg_data[4:0];
                    default:         ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg     <= request;
                        pending_reg <= 1'b1;
                        case (request.mode)
                            MODE_PLOT:
                            begin
                                x_reg     <= {1'b0, request.pixel_x};
                                y_reg     <= request.pixel_y;
                                bits_reg  <= PLOT_BIT;
                                rem_reg   <= 6'd1;
                                state_reg <= ST_SCAN;
                            end
                            MODE_GLYPH:
                            begin
                                x_reg    <= {1'b0, cursor_col_reg};
                                y_reg    <= 8'(cursor_row_reg) + 8'(request.row_number);
                                bits_reg <= request.row_bits;
                                // rows past the glyph draw nothing
                                rem_reg  <= row_past ? 6'd0 : glyph_w;
                                if (!row_past && request.row_number == 5'd0)
                                    state_reg <= ST_NEWC;
                                else
                                    state_reg <= ST_SCAN;
                            end
                            MODE_READ:
                            begin
                                state_reg <= ST_RD_ISSUE;
                            end
                            default:
                            begin
                                fill_reg  <= '0;
                                state_reg <= ST_FILL;
                            end
                        endcase
                    end
                end

                ST_FILL:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    if (fill_reg == ADDR_W'(FRAME_BYTES - 1))
                    begin
                        if (!pending_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (req_reg.mode == MODE_CLEAR)
                        begin
                            frame_byte_reg <= BYTE_ZERO;
                            done_reg       <= 1'b1;
                            pending_reg    <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_NEWC:
                begin
                    cursor_col_reg <= nc_x2;
                    cursor_row_reg <= nc_y2[6:0];
                    x_reg          <= {1'b0, nc_x2};
                    y_reg          <= {1'b0, nc_y2[6:0]};
                    state_reg      <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    if (rem_reg == 6'd0)
                    begin
                        if (req_reg.mode == MODE_GLYPH && last_row)
                            cursor_col_reg <= col_sat;
                        frame_byte_reg <= BYTE_ZERO;
                        done_reg       <= 1'b1;
                        pending_reg    <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                    else if (plot_hit && need_flip)
                    begin
                        // flip background, refill, then retry this pixel
                        bg_reg    <= ~bg_reg;
                        fill_reg  <= '0;
                        state_reg <= ST_FILL;
                    end
                    else if (plot_hit)
                    begin
                        state_reg <= ST_RMW;
                    end
                    else
                    begin
                        bits_reg <= bits_reg << 1;
                        rem_reg  <= rem_reg - 6'd1;
                        x_reg    <= x_reg + 9'd1;
                    end
                end

                ST_RMW:
                begin
                    bits_reg  <= bits_reg << 1;
                    rem_reg   <= rem_reg - 6'd1;
                    x_reg     <= x_reg + 9'd1;
                    state_reg <= ST_SCAN;
                end

                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_DATA;
                end

                ST_RD_DATA:
                begin
                    frame_byte_reg <= rd_in ? ram_rd_data : BYTE_ZERO;
                    done_reg       <= 1'b1;
                    pending_reg    <= 1'b0;
                    state_reg      <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy                    = (state_reg != ST_IDLE);
    assign done                    = done_reg;
    assign result.frame_byte       = frame_byte_reg;
    assign result.background_white = bg_reg;

endmodule

// File: hw/rtl/pftr_checker.sv
module pftr_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // result strobe only once the engine has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // a taken request keeps the engine busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request");

    // no result in the cycle right after a request is taken
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

endmodule

bind page_framebuffer_text_renderer pftr_checker u_pftr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

// File: tb/page_framebuffer_text_renderer_tb.sv
module page_framebuffer_text_renderer_tb;

    import pftr_pkg::*;

    // ------------------------------------------------------------------
    // Frame/text scoreboard: keeps its own copy of the frame store,
    // background color, text cursor and font registers, and predicts the
    // result of every accepted request in acceptance order.
    // ------------------------------------------------------------------
    class render_scoreboard;
        bit [7:0]    frame [FRAME_BYTES];
        bit          bg_white;
        int unsigned cur_col;
        int unsigned cur_row;
        bit [5:0]    font_w;
        bit [5:0]    font_h;
        bit [6:0]    org_x;
        bit [4:0]    org_y;
        result_t     expected_results[$];
        int          mismatches;

        function new();
            foreach (frame[i]) frame[i] = BYTE_ZERO;
            bg_white   = 1'b0;
            cur_col    = 0;
            cur_row    = 0;
            font_w     = FONT_WIDTH_RST;
            font_h     = FONT_HEIGHT_RST;
            org_x      = '0;
            org_y      = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] data);
            case (idx)
                CFG_FONT_WIDTH:  font_w = data[5:0];
                CFG_FONT_HEIGHT: font_h = data[5:0];
                CFG_START_X:     org_x  = data;
                CFG_START_Y:     org_y  = data[4:0];
                default: ;
            endcase
        endfunction

        // out-of-range font sizes are clamped, zero counts as one
        function int unsigned glyph_w();
            if (font_w == 0) return 1;
            if (font_w > MAX_GLYPH_WIDTH) return MAX_GLYPH_WIDTH;
            return font_w;
        endfunction

        function int unsigned glyph_h();
            if (font_h == 0) return 1;
            if (font_h > MAX_GLYPH_HEIGHT) return MAX_GLYPH_HEIGHT;
            return font_h;
        endfunction

        function void fill_frame();
            foreach (frame[i]) frame[i] = bg_white ? BYTE_ONES : BYTE_ZERO;
        endfunction

        function void put_pixel(int unsigned x, int unsigned y, bit white);
            int unsigned idx;
            if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
            if ((y >> 3) >= PAGE_COUNT) return;
            idx = (y >> 3) * PANEL_WIDTH + x;
            // drawing in the background color flips it and refills
            if (white == bg_white) begin
                bg_white = !white;
                fill_frame();
            end
            if (white)
                frame[idx] = frame[idx] | (BYTE_LSB << (y & 7));
            else
                frame[idx] = frame[idx] & ~(BYTE_LSB << (y & 7));
        endfunction

        function void draw_glyph_row(request_t r);
            int unsigned w, h, rn, x, y, c;
            w  = glyph_w();
            h  = glyph_h();
            rn = r.row_number;
            if (rn >= h) return;
            if (rn == 0) begin
                x = cur_col;
                y = cur_row;
                if (r.string_start) begin
                    x = org_x;
                    y = org_y;
                end
                if (x + w > PANEL_WIDTH) begin
                    x = org_x;
                    y = y + h;
                end
                if (y + h > PANEL_HEIGHT) begin
                    x = org_x;
                    y = org_y;
                end
                cur_col = x & 'hff;
                cur_row = y & 'h7f;
            end
            for (c = 0; c < w; c++)
                if (r.row_bits[31 - c]) put_pixel(cur_col + c, cur_row + rn, r.draw_white);
            if (rn == h - 1)
                cur_col = (cur_col + w > 255) ? 255 : cur_col + w;
        endfunction

        function result_t predict(request_t r);
            result_t     res;
            int unsigned page;
            res.frame_byte = BYTE_ZERO;
            case (r.mode)
                MODE_PLOT:  put_pixel(r.pixel_x, r.pixel_y, r.draw_white);
                MODE_GLYPH: draw_glyph_row(r);
                MODE_READ: begin
                    page = r.pixel_y >> 3;
                    if (r.pixel_x < PANEL_WIDTH && page < PAGE_COUNT)
                        res.frame_byte = frame[page * PANEL_WIDTH + r.pixel_x];
                end
                MODE_CLEAR: fill_frame();
                default: ;
            endcase
            res.background_white = bg_white;
            return res;
        endfunction

        function void note_request(request_t r);
            expected_results.push_back(predict(r));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request outstanding: frame_byte %02h bg %0d",
                             got.frame_byte, got.background_white);
                return;
            end
            want = expected_results.pop_front();
            if (got.frame_byte !== want.frame_byte ||
                got.background_white !== want.background_white) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected frame_byte %02h bg %0d, ",
                              "got frame_byte %02h bg %0d"},
                             want.frame_byte, want.background_white,
                             got.frame_byte, got.background_white);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    request_t   request;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;
    logic       done;
    result_t    result;

    render_scoreboard sb = new();

    int burst_left = 0;   // requests left in the current burst
    int items_sent = 0;   // requests of the current phase that do real work

    page_framebuffer_text_renderer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Results cannot be held off: every done pulse is checked right away.
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(result);
    end

    function automatic request_t make_req(logic [1:0] mode, int x, int y,
                                          int white, logic [31:0] bits, int rn,
                                          int ss);
        request_t r;
        r.mode         = mode;
        r.pixel_x      = 8'(x);
        r.pixel_y      = 8'(y);
        r.draw_white   = 1'(white);
        r.row_bits     = bits;
        r.row_number   = 5'(rn);
        r.string_start = 1'(ss);
        return r;
    endfunction

    // glyph row patterns: solid, empty, single column, or random
    function automatic logic [31:0] glyph_bits();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Issues one request; called and returning at a falling edge. Start
    // stays high across a burst, and a random gap separates bursts.
    task automatic issue(request_t r);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        sb.note_request(r);
        // rows past the glyph height are ignored by the block
        if (!(r.mode == MODE_GLYPH && r.row_number >= sb.glyph_h())) items_sent++;
        @(negedge clk);
    endtask

    // Holds off until every outstanding request has its result and the
    // block is idle.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
        while (busy) @(negedge clk);
        burst_left = 0;
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic put_reg(logic [1:0] idx, logic [6:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        sb.set_reg(idx, data);
    endtask

    // One font setting, then a random mix of requests. Half the traffic is text
    // strings, mostly well-formed, so the cursor wraps and advances; the rest
    // is plots, reads, clears, repeated last rows and raw noise.
    task automatic run_phase(int w, int h_cfg, int x, int y, int target);
        int          sel, nch, ch, row, rn, h, max_ch;
        bit          white, broken, ss;
        logic [63:0] raw;
        drain();
        put_reg(CFG_FONT_WIDTH, 7'(w));
        put_reg(CFG_FONT_HEIGHT, 7'(h_cfg));
        put_reg(CFG_START_X, 7'(x));
        put_reg(CFG_START_Y, 7'(y));
        cfg_we <= 1'b0;
        items_sent = 0;
        while (items_sent < target) begin
            sel = $urandom_range(0, 99);
            h   = sb.glyph_h();
            if (sel < 50) begin
                // text string; color mostly opposite the background
                white  = ($urandom_range(0, 9) == 0) ? sb.bg_white : !sb.bg_white;
                max_ch = 60 / h;
                if (max_ch < 1) max_ch = 1;
                if (max_ch > 6) max_ch = 6;
                nch    = $urandom_range(1, max_ch);
                broken = ($urandom_range(0, 6) == 0);
                for (ch = 0; ch < nch; ch++) begin
                    for (row = 0; row < h; row++) begin
                        rn = broken ? $urandom_range(0, h - 1) : row;
                        // string_start only matters on row 0
                        ss = (rn == 0) ? (ch == 0) : 1'($urandom_range(0, 1));
                        issue(make_req(MODE_GLYPH, $urandom, $urandom, white,
                                       glyph_bits(), rn, ss));
                        if (broken && $urandom_range(0, 3) == 0) break;
                    end
                end
            end
            else if (sel < 65) begin
                if ($urandom_range(0, 3) == 0)
                    issue(make_req(MODE_PLOT, $urandom, $urandom, $urandom_range(0, 1),
                                   $urandom, $urandom, $urandom_range(0, 1)));
                else
                    issue(make_req(MODE_PLOT, $urandom_range(0, PANEL_WIDTH - 1),
                                   $urandom_range(0, PANEL_HEIGHT - 1), $urandom_range(0, 1),
                                   $urandom, $urandom, $urandom_range(0, 1)));
            end
            else if (sel < 80) begin
                if ($urandom_range(0, 4) == 0)
                    issue(make_req(MODE_READ, $urandom, $urandom, $urandom_range(0, 1),
                                   $urandom, $urandom, $urandom_range(0, 1)));
                else
                    issue(make_req(MODE_READ, $urandom_range(0, PANEL_WIDTH - 1),
                                   $urandom_range(0, PANEL_HEIGHT - 1), $urandom_range(0, 1),
                                   $urandom, $urandom, $urandom_range(0, 1)));
            end
            else if (sel < 85) begin
                issue(make_req(MODE_CLEAR, $urandom, $urandom, $urandom_range(0, 1),
                               $urandom, $urandom, $urandom_range(0, 1)));
            end
            else if (sel < 92) begin
                // last glyph row over and over: cursor runs off the panel
                // and saturates
                repeat ($urandom_range(4, 40))
                    issue(make_req(MODE_GLYPH, $urandom, $urandom, !sb.bg_white,
                                   glyph_bits(), h - 1, $urandom_range(0, 1)));
            end
            else if (sel < 98) begin
                raw = {$urandom, $urandom};
                issue(raw[$bits(request_t)-1:0]);
            end
            else begin
                drain();
            end
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FONT_WIDTH;
        cfg_data  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset font (8 x 16, origin 0,0), black background.
        issue(make_req(MODE_READ, 8'd0, 8'd0, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_PLOT, 8'd0, 8'd0, 1'b1, '0, 5'd0, 1'b0));
        issue(make_req(MODE_PLOT, 8'd127, 8'd31, 1'b1, '1, 5'd31, 1'b1));
        // off-panel pixels are dropped and never flip the background
        issue(make_req(MODE_PLOT, 8'd128, 8'd5, 1'b1, '0, 5'd0, 1'b0));
        issue(make_req(MODE_PLOT, 8'd3, 8'd32, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_PLOT, 8'd255, 8'd255, 1'b1, '0, 5'd0, 1'b0));
        issue(make_req(MODE_READ, 8'd0, 8'd0, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_READ, 8'd127, 8'd31, 1'b0, '0, 5'd0, 1'b0));
        // reads outside the frame return zero
        issue(make_req(MODE_READ, 8'd128, 8'd0, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_READ, 8'd0, 8'd32, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_READ, 8'd255, 8'd255, 1'b1, '1, 5'd31, 1'b1));
        // black on black: background flips to white and refills
        issue(make_req(MODE_PLOT, 8'd5, 8'd5, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_READ, 8'd5, 8'd0, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_CLEAR, 8'd0, 8'd0, 1'b0, '0, 5'd0, 1'b0));
        // glyph: string start, late string_start ignored, last row,
        // rows beyond the glyph height
        issue(make_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 32'hffff_ffff, 5'd0, 1'b1));
        issue(make_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 32'haaaa_aaaa, 5'd3, 1'b1));
        issue(make_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 32'h0000_0000, 5'd15, 1'b0));
        issue(make_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 32'hffff_ffff, 5'd16, 1'b0));
        issue(make_req(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 32'hffff_ffff, 5'd31, 1'b0));
        issue(make_req(MODE_GLYPH, 8'hff, 8'hff, 1'b0, 32'h8000_0001, 5'd0, 1'b0));
        issue(make_req(MODE_READ, 8'd8, 8'd0, 1'b0, '0, 5'd0, 1'b0));
        issue(make_req(MODE_CLEAR, 8'hff, 8'hff, 1'b1, '1, 5'd31, 1'b1));
        issue(make_req(MODE_READ, 8'd100, 8'd24, 1'b0, '0, 5'd0, 1'b0));

        // Random phases: reset font, both extremes, clamped sizes,
        // masked upper data bits, typical fonts, then random settings.
        run_phase(8, 16, 0, 0, 90);
        run_phase(1, 1, 0, 0, 90);
        run_phase(32, 32, 127, 31, 60);
        run_phase(0, 0, 64, 9, 70);
        run_phase(63, 63, 3, 5, 60);
        run_phase('h7f, 'h45, 120, 'h7f, 60);
        run_phase(6, 8, 0, 0, 120);
        run_phase(5, 7, 10, 1, 120);
        repeat (3)
            run_phase($urandom_range(1, 32), $urandom_range(1, 32),
                      $urandom_range(0, 127), $urandom_range(0, 31), 100);

        // Let outstanding results arrive, then a tail longer than the
        // slowest request (glyph row plus a full refill).
        start <= 1'b0;
        for (wait_cycles = 0; sb.pending() != 0 && wait_cycles < 5000; wait_cycles++)
            @(negedge clk);
        repeat (1000) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("page_framebuffer_text_renderer regression: pass");
        else
            $display("page_framebuffer_text_renderer regression: fail");
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("page_framebuffer_text_renderer regression: fail");
        $finish;
    end

endmodule
